// ----- rtl/srmv_pkg.sv -----
// Shared constants and request codes for the sparse row matrix-vector core.
// No dependencies; imported by sparse_row_matvec_core.
`default_nettype none

package srmv_pkg;

  // Vector store geometry
  localparam int unsigned VectorDepth = 1024;
  localparam int unsigned VecAw       = $clog2(VectorDepth);

  // Field widths
  localparam int unsigned IdxW     = 10;
  localparam int unsigned ValW     = 32;
  localparam int unsigned AccW     = 64;
  localparam int unsigned RowW     = 16;
  localparam int unsigned ColCntW  = 11;
  localparam int unsigned RowCntW  = 17;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 17;

  // Stream word widths
  localparam int unsigned InDataW  = 88;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned OutUserW = 2;

  // Reset values of the configuration registers
  localparam logic [ColCntW-1:0] ColCountRst = ColCntW'(1024);
  localparam logic [RowCntW-1:0] RowCountRst = RowCntW'(65536);

  // Request kinds carried in tuser
  typedef enum logic [1:0] {
    ReqLoad     = 2'd0,
    ReqNonzero  = 2'd1,
    ReqEmptyRow = 2'd2,
    ReqNone     = 2'd3
  } req_type_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgColumnCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgRowCount    = 1'd1;

endpackage

`default_nettype wire

// ----- rtl/sparse_row_matvec_core.sv -----
// Sparse matrix times dense vector in compressed-row order, Q16.16 in, Q32.32 out.
// Top level; one module holding the vector memory and the MAC pipeline.
// Depends on srmv_pkg.
//
// One word is taken every clock cycle unless stalled, with no gaps between
// loads, nonzeros and empty-row words. A word runs through three stages: accept
// and vector memory read, 32x32 multiply, then a 64-bit saturating add into the
// row accumulator. A row result leaves through the accept, multiply and output
// registers after the word that closes the row. A finished result waits in the
// output register while the pipeline keeps running; the slave side stalls only
// when a second row closes while the first result has not been taken. A vector
// element loaded in one cycle is seen by a nonzero in the next. The vector
// memory is not cleared at reset: load every element before a nonzero uses it.
`default_nettype none

module sparse_row_matvec_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [srmv_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [srmv_pkg::CfgDataW-1:0]     cfg_data_i,
  // Input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: element_index[9:0], vector_value[41:10], matrix_value[73:42],
  //        column[83:74], zero[87:84]
  input  wire logic [srmv_pkg::InDataW-1:0]      s_axis_tdata,
  // tuser: req_type[1:0]
  input  wire logic [srmv_pkg::InUserW-1:0]      s_axis_tuser,
  input  wire logic                              s_axis_tlast,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: row_index[15:0], row_sum[79:16]
  output logic [srmv_pkg::OutDataW-1:0]          m_axis_tdata,
  // tuser: saturated[0], bad_column[1]
  output logic [srmv_pkg::OutUserW-1:0]          m_axis_tuser
);

  import srmv_pkg::*;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  // Configuration registers
  logic [ColCntW-1:0] col_count_q;
  logic [RowCntW-1:0] row_count_q;

  // Input word fields
  req_type_e        in_req;
  logic [IdxW-1:0]  in_eidx;
  logic [ValW-1:0]  in_vval;
  logic [ValW-1:0]  in_mval;
  logic [IdxW-1:0]  in_col;
  logic             in_acc;
  logic             in_bad_col;

  // Pipeline control and payload
  logic             stall;
  logic             v1_q, close1_q, nz1_q, bad1_q;
  logic [ValW-1:0]  mval1_q;
  logic [ValW-1:0]  rdata_q;
  logic             v2_q, close2_q, nz2_q, bad2_q;
  logic signed [AccW-1:0] prod2_q;

  // Row state
  logic signed [AccW-1:0] acc_q;
  logic             sat_q, err_q;
  logic [RowW-1:0]  row_q;

  // Accumulate stage
  logic signed [AccW-1:0] addend, sum_raw, acc_new;
  logic             ovf, sat_new, err_new;
  logic [RowCntW-1:0] row_next;
  logic             retire, emit;

  // Output register
  logic             out_valid_q;
  logic [RowW-1:0]  out_row_q;
  logic [AccW-1:0]  out_sum_q;
  logic             out_sat_q, out_err_q;

  logic [ValW-1:0]  vec_mem [VectorDepth];

  // Unpack the input word
  assign in_req  = req_type_e'(s_axis_tuser);
  assign in_eidx = s_axis_tdata[9:0];
  assign in_vval = s_axis_tdata[41:10];
  assign in_mval = s_axis_tdata[73:42];
  assign in_col  = s_axis_tdata[83:74];

  assign in_bad_col = ({1'b0, in_col} >= col_count_q) || (32'(in_col) >= VectorDepth);

  // Stall only when a second result would overrun a waiting one
  assign stall         = v2_q && close2_q && out_valid_q && !m_axis_tready;
  assign s_axis_tready = !stall;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= ColCountRst;
      row_count_q <= RowCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgColumnCount: col_count_q <= cfg_data_i[ColCntW-1:0];
        CfgRowCount:    row_count_q <= cfg_data_i[RowCntW-1:0];
        default: ;
      endcase
    end
  end

  // Vector memory: write on load, registered read on nonzero
  always_ff @(posedge clk_i) begin
    if (in_acc && in_req == ReqLoad && 32'(in_eidx) < VectorDepth) begin
      vec_mem[in_eidx[VecAw-1:0]] <= in_vval;
    end
    if (in_acc && in_req == ReqNonzero) begin
      rdata_q <= vec_mem[in_col[VecAw-1:0]];
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (!stall) begin
      v1_q <= in_acc && (in_req == ReqNonzero || in_req == ReqEmptyRow);
      v2_q <= v1_q;
    end
  end

  // Pipeline payload: decode, then multiply
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      close1_q <= (in_req == ReqEmptyRow) || (in_req == ReqNonzero && s_axis_tlast);
      nz1_q    <= (in_req == ReqNonzero) && !in_bad_col;
      bad1_q   <= (in_req == ReqNonzero) && in_bad_col;
      mval1_q  <= in_mval;
      close2_q <= close1_q;
      nz2_q    <= nz1_q;
      bad2_q   <= bad1_q;
      prod2_q  <= $signed(mval1_q) * $signed(rdata_q);
    end
  end

  // Saturating accumulate and row bookkeeping
  always_comb begin
    addend   = nz2_q ? prod2_q : '0;
    sum_raw  = acc_q + addend;
    ovf      = (acc_q[AccW-1] == addend[AccW-1]) && (sum_raw[AccW-1] != acc_q[AccW-1]);
    acc_new  = ovf ? (acc_q[AccW-1] ? AccMin : AccMax) : sum_raw;
    sat_new  = sat_q || ovf;
    err_new  = err_q || bad2_q;
    row_next = {1'b0, row_q} + RowCntW'(1);
    if (row_next >= row_count_q || row_next[RowCntW-1]) begin
      row_next = '0;
    end
  end

  assign retire = v2_q && !stall;
  assign emit   = retire && close2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
      err_q <= 1'b0;
      row_q <= '0;
    end else if (retire) begin
      if (close2_q) begin
        acc_q <= '0;
        sat_q <= 1'b0;
        err_q <= 1'b0;
        row_q <= row_next[RowW-1:0];
      end else begin
        acc_q <= acc_new;
        sat_q <= sat_new;
        err_q <= err_new;
      end
    end
  end

  // Output register: hold a result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_row_q <= row_q;
      out_sum_q <= acc_new;
      out_sat_q <= sat_new;
      out_err_q <= err_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_sum_q, out_row_q};
  assign m_axis_tuser  = {out_err_q, out_sat_q};

  // Row state clears after every closed row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (acc_q == '0) && !sat_q && !err_q)
    else $error("row state not cleared after row close");

  // Row counter either wraps to zero or steps by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (row_q == '0) || (row_q == $past(row_q) + RowW'(1)))
    else $error("row counter jumped");

  // A blocked closing word stays in the last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> v2_q && close2_q && out_valid_q)
    else $error("closing word lost during stall");

  // A new result is only loaded when the output register is free or draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !out_valid_q || m_axis_tready)
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ----- tb/sparse_row_matvec_core_test.sv -----
// Self-checking testbench for sparse_row_matvec_core: vector loads, CSR nonzeros, row results.
// Predicts each row sum with its own saturating Q32.32 accumulator and compares every result word.
// Depends on srmv_pkg and the core RTL only.

module sparse_row_matvec_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srmv_pkg::*;

  // Three pipeline stages plus margin for words that close no row
  localparam int SettleCycles = 8;
  localparam int EndWaitCycles = 10000;
  localparam longint RunLimitNs = 64'd20_000_000;
  localparam int DirRows = 24;
  // Low vector window loaded up front; nonzeros inside the matrix stay in it or use the top entry
  localparam int LoadSpan = 32;

  // One input word, unpacked into its fields
  typedef struct packed {
    req_type_e          req;
    logic [IdxW-1:0]    elem;
    logic [ValW-1:0]    vval;
    logic [ValW-1:0]    mval;
    logic [IdxW-1:0]    col;
    logic               last;
  } in_word_t;

  // One row result word
  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [AccW-1:0]    sum;
    logic               sat;
    logic               bad;
  } row_result_t;

  // Directed stimulus row: a register write or a word, optionally with a typed result
  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_val;
    in_word_t            w;
    logic                typed;
    row_result_t         want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  // Predicted block state and register copies
  logic [ValW-1:0]     vec_mem [VectorDepth];
  logic [AccW-1:0]     acc_q32;
  logic [RowW-1:0]     row_ctr;
  logic                sat_seen;
  logic                badcol_seen;
  logic [ColCntW-1:0]  col_count_cfg;
  logic [RowCntW-1:0]  row_count_cfg;

  row_result_t         pending_rows [$];
  int                  fail_count = 0;
  bit                  steady = 1'b0;
  dir_row_t            dir_rows [DirRows];

  sparse_row_matvec_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // Advance the predicted state by one accepted word; flag a closed row
  task automatic accumulate_word(input in_word_t w, output bit closes, output row_result_t res);
    longint          prod;
    logic [AccW-1:0] prod_bits;
    logic [AccW-1:0] sum;
    int              nxt;
    closes = 1'b0;
    res = '0;
    case (w.req)
      ReqLoad: begin
        vec_mem[w.elem] = w.vval;
      end
      ReqNonzero: begin
        if (w.col >= col_count_cfg) begin
          badcol_seen = 1'b1;
        end else begin
          prod = longint'($signed(w.mval)) * longint'($signed(vec_mem[w.col]));
          prod_bits = prod;
          sum = acc_q32 + prod_bits;
          // clamp on signed overflow and go on from the clamped value
          if (acc_q32[AccW-1] == prod_bits[AccW-1] && sum[AccW-1] != acc_q32[AccW-1]) begin
            sat_seen = 1'b1;
            sum = acc_q32[AccW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
          end
          acc_q32 = sum;
        end
        closes = w.last;
      end
      ReqEmptyRow: begin
        closes = 1'b1;
      end
      ReqNone: begin
      end
    endcase
    if (closes) begin
      res = '{row_ctr, acc_q32, sat_seen, badcol_seen};
      nxt = int'(row_ctr) + 1;
      if (nxt >= int'(row_count_cfg) || nxt > 65535) nxt = 0;
      row_ctr = RowW'(nxt);
      acc_q32 = '0;
      sat_seen = 1'b0;
      badcol_seen = 1'b0;
    end
  endtask

  // Offer one word, after a random gap outside the steady stretch; predict once it is taken
  task automatic send_word(input in_word_t w, input bit typed, input row_result_t want);
    bit          closes;
    row_result_t res;
    while (!steady && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({w.col, w.mval, w.vval, w.elem});
    s_axis_tuser  <= w.req;
    s_axis_tlast  <= w.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    accumulate_word(w, closes, res);
    if (closes) pending_rows.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every row has come out and the pipeline is empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgColumnCount) col_count_cfg = val[ColCntW-1:0];
    else row_count_cfg = val[RowCntW-1:0];
    @(negedge clk_i);
  endtask

  // Q16.16 values biased toward the extremes and small magnitudes
  function automatic logic [ValW-1:0] pick_q16();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return ValW'($urandom_range(32'h0020_0000) - 32'h0010_0000);
      default: return ValW'($urandom);
    endcase
  endfunction

  // Mostly columns in the matrix and loaded window; some past a matrix narrower than the store
  function automatic logic [IdxW-1:0] pick_column();
    int span;
    span = (int'(col_count_cfg) > VectorDepth) ? VectorDepth : int'(col_count_cfg);
    if (span > 0 && $urandom_range(9) < 8) begin
      if (span == VectorDepth && $urandom_range(7) == 0) return IdxW'(VectorDepth - 1);
      return IdxW'($urandom_range(((span < LoadSpan) ? span : LoadSpan) - 1));
    end
    if (span < VectorDepth) return IdxW'($urandom_range(VectorDepth - 1, span));
    return IdxW'($urandom_range(LoadSpan - 1));
  endfunction

  function automatic in_word_t rand_word(input req_type_e req);
    in_word_t w;
    w.req  = req;
    w.elem = IdxW'($urandom);
    w.vval = pick_q16();
    w.mval = pick_q16();
    w.col  = IdxW'($urandom);
    w.last = 1'($urandom);
    return w;
  endfunction

  // Random rows of nonzeros, with loads, ignored words and empty rows mixed in
  task automatic send_random_rows(input int budget);
    int       sent;
    int       len;
    bit       close_by_empty;
    in_word_t w;
    sent = 0;
    while (sent < budget) begin
      len = $urandom_range(6, 0);
      close_by_empty = ($urandom_range(7) == 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0) begin
          send_word(rand_word(ReqLoad), 1'b0, '0);
          sent++;
        end
        if ($urandom_range(19) == 0) send_word(rand_word(ReqNone), 1'b0, '0);
        w = rand_word(ReqNonzero);
        w.col = pick_column();
        w.last = (k == len - 1) && !close_by_empty;
        send_word(w, 1'b0, '0);
        sent++;
      end
      if (len == 0 || close_by_empty) begin
        send_word(rand_word(ReqEmptyRow), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Directed table builders
  function automatic dir_row_t ld(input logic [IdxW-1:0] idx, input logic [ValW-1:0] val);
    dir_row_t r;
    r = '0;
    r.w.req  = ReqLoad;
    r.w.elem = idx;
    r.w.vval = val;
    return r;
  endfunction

  function automatic dir_row_t nz(input logic [IdxW-1:0] col, input logic [ValW-1:0] m,
                                  input logic last);
    dir_row_t r;
    r = '0;
    r.w.req  = ReqNonzero;
    r.w.col  = col;
    r.w.mval = m;
    r.w.last = last;
    return r;
  endfunction

  function automatic dir_row_t er();
    dir_row_t r;
    r = '0;
    r.w.req = ReqEmptyRow;
    return r;
  endfunction

  function automatic dir_row_t unknown_req();
    dir_row_t r;
    r = '0;
    r.w.req  = ReqNone;
    r.w.mval = 32'h7FFF_FFFF;
    r.w.last = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t cf(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic dir_row_t checked(input dir_row_t r, input logic [RowW-1:0] row,
                                       input logic [AccW-1:0] sum, input logic sat,
                                       input logic bad);
    r.typed = 1'b1;
    r.want  = '{row, sum, sat, bad};
    return r;
  endfunction

  // Randomize ready every cycle unless in the steady stretch
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 14);
  end

  // Compare each taken row word with the oldest prediction
  always @(posedge clk_i) begin
    row_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected row %0d", m_axis_tdata[RowW-1:0]));
      end else begin
        want = pending_rows.pop_front();
        if (m_axis_tdata[RowW-1:0] != want.row)
          report_mismatch($sformatf("row index %0d, want %0d", m_axis_tdata[RowW-1:0], want.row));
        if (m_axis_tdata[RowW +: AccW] != want.sum)
          report_mismatch($sformatf("row %0d sum %h, want %h", want.row,
                                    m_axis_tdata[RowW +: AccW], want.sum));
        if (m_axis_tuser[0] != want.sat)
          report_mismatch($sformatf("row %0d saturated %b, want %b", want.row,
                                    m_axis_tuser[0], want.sat));
        if (m_axis_tuser[1] != want.bad)
          report_mismatch($sformatf("row %0d bad_column %b, want %b", want.row,
                                    m_axis_tuser[1], want.bad));
      end
    end
  end

  initial begin
    #(RunLimitNs);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int waited;
    acc_q32       = '0;
    row_ctr       = '0;
    sat_seen      = 1'b0;
    badcol_seen   = 1'b0;
    col_count_cfg = ColCountRst;
    row_count_cfg = RowCountRst;

    dir_rows = '{
      ld(10'd0, 32'h0001_0000),
      ld(10'd1023, 32'h7FFF_FFFF),
      ld(10'd1, 32'h8000_0000),
      ld(10'd2, 32'hFFFF_FFFF),
      checked(er(), 16'd0, 64'h0, 1'b0, 1'b0),
      checked(nz(10'd0, 32'h0001_0000, 1'b1), 16'd1, 64'h0000_0001_0000_0000, 1'b0, 1'b0),
      // two most-negative squares overflow upward
      nz(10'd1, 32'h8000_0000, 1'b0),
      nz(10'd1, 32'h8000_0000, 1'b0),
      checked(nz(10'd2, 32'h7FFF_FFFF, 1'b1), 16'd2, 64'h7FFF_FFFF_8000_0000, 1'b1, 1'b0),
      nz(10'd1023, 32'h7FFF_FFFF, 1'b0),
      nz(10'd1023, 32'h8000_0000, 1'b0),
      unknown_req(),
      // empty row closes the pending sum
      checked(er(), 16'd3, 64'hFFFF_FFFF_8000_0001, 1'b0, 1'b0),
      // three large negative products clamp at the bottom
      nz(10'd1, 32'h7FFF_FFFF, 1'b0),
      nz(10'd1, 32'h7FFF_FFFF, 1'b0),
      checked(nz(10'd1, 32'h7FFF_FFFF, 1'b1), 16'd4, 64'h8000_0000_0000_0000, 1'b1, 1'b0),
      checked(nz(10'd2, 32'h0001_0000, 1'b1), 16'd5, 64'hFFFF_FFFF_FFFF_0000, 1'b0, 1'b0),
      cf(CfgColumnCount, 17'd3),
      cf(CfgRowCount, 17'd1),
      // column past the matrix adds nothing but marks the row
      nz(10'd1023, 32'h7FFF_FFFF, 1'b0),
      checked(nz(10'd0, 32'h0001_0000, 1'b1), 16'd6, 64'h0000_0001_0000_0000, 1'b0, 1'b1),
      checked(er(), 16'd0, 64'h0, 1'b0, 1'b0),
      cf(CfgColumnCount, 17'd0),
      checked(nz(10'd0, 32'h7FFF_FFFF, 1'b1), 16'd0, 64'h0, 1'b0, 1'b1)
    };

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Load the low window; nonzeros inside the matrix read only loaded entries
    for (int i = 0; i < LoadSpan; i++) begin
      send_word('{ReqLoad, IdxW'(i), pick_q16(), 32'h0, 10'd0, 1'b0}, 1'b0, '0);
    end

    // Walk the directed table
    for (int i = 0; i < DirRows; i++) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_cfg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Full matrix, counter at its reset span; pause once for every row mid-phase
    wait_idle();
    write_cfg(CfgColumnCount, 17'd1024);
    write_cfg(CfgRowCount, 17'h10000);
    send_random_rows(70);
    wait_idle();
    send_random_rows(60);

    // One column, one row
    wait_idle();
    write_cfg(CfgColumnCount, 17'd1);
    write_cfg(CfgRowCount, 17'd1);
    send_random_rows(50);

    // Zero sizes: every column bad, counter pinned
    wait_idle();
    write_cfg(CfgColumnCount, 17'd0);
    write_cfg(CfgRowCount, 17'd0);
    send_random_rows(30);

    // Column count past the store, short wrap, no idling on either side
    wait_idle();
    steady = 1'b1;
    write_cfg(CfgColumnCount, 17'd2047);
    write_cfg(CfgRowCount, 17'd5);
    send_random_rows(80);
    wait_idle();
    steady = 1'b0;

    write_cfg(CfgColumnCount, 17'd512);
    write_cfg(CfgRowCount, 17'd3);
    send_random_rows(50);

    // Row count beyond the counter width: the counter keeps stepping
    wait_idle();
    write_cfg(CfgColumnCount, 17'd1024);
    write_cfg(CfgRowCount, 17'h1FFFF);
    send_random_rows(30);

    // Drain, then let the pipeline settle
    s_axis_tvalid <= 1'b0;
    for (waited = 0; pending_rows.size() != 0 && waited < EndWaitCycles; waited++) begin
      @(negedge clk_i);
    end
    if (pending_rows.size() != 0)
      report_mismatch($sformatf("%0d rows never came out", pending_rows.size()));
    repeat (SettleCycles) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
